FILE: design/omrb_pkg.sv
// Shared constants, types and helpers of the overwrite message ring buffer.
package omrb_pkg;

	localparam int SLOT_BYTES = 32;
	localparam int SLOT_COUNT = 16;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int IDX_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
	localparam int ADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES);
	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] pop_byte;
		logic              pop_last;
		logic [LEN_W-1:0]  message_length;
	} res_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(idx);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
		return (slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot + 1'b1;
	endfunction

endpackage

FILE: design/omrb_req_if.sv
// Input channel of the ring buffer: one command item per handshake.
interface omrb_req_if import omrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] push_byte;
	logic              push_last;

	modport source(output valid, cmd, push_byte, push_last, input ready);
	modport sink(input valid, cmd, push_byte, push_last, output ready);
endinterface

FILE: design/omrb_rsp_if.sv
// Output channel of the ring buffer: one popped byte or empty status per handshake.
interface omrb_rsp_if import omrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic [BYTE_W-1:0] pop_byte;
	logic              pop_last;
	logic [LEN_W-1:0]  message_length;

	modport source(output valid, status, pop_byte, pop_last, message_length, input ready);
	modport sink(input valid, status, pop_byte, pop_last, message_length, output ready);
endinterface

FILE: design/omrb_out_stage.sv
// Output register of the ring buffer that decouples result staging from the consumer.
module omrb_out_stage import omrb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_valid,
	input  res_t           res,
	output logic           take,
	omrb_rsp_if.source     rsp
);

	logic out_v_q;
	res_t out_q;

	assign take = load_valid && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_q.status;
	assign rsp.pop_byte       = out_q.pop_byte;
	assign rsp.pop_last       = out_q.pop_last;
	assign rsp.message_length = out_q.message_length;

endmodule

FILE: design/overwrite_message_ring_buffer_core.sv
// Top level of the overwrite-oldest message ring buffer with its byte and length memories.
//
//   channel | dir | payload                                      | accepted when
//   req     | in  | cmd, push_byte, push_last                    | req.valid && req.ready
//   rsp     | out | status, pop_byte, pop_last, message_length   | rsp.valid && rsp.ready
//
// Push bytes stream at one per cycle while no pop is in flight.
// A pop of a stored message yields one byte per cycle while the consumer takes them,
// set by the single read port of the byte memory; after an empty pop,
// the next item waits until its status leaves the read stage.
// Reset empties the ring at once through per-slot occupancy flops; no clearing pass.
// A stalled consumer holds the byte stream; req.ready stays low while a pop is active.
module overwrite_message_ring_buffer_core import omrb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	omrb_req_if.sink   req,
	omrb_rsp_if.source rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t                  state_q;
	logic [SLOT_W-1:0]       head_q;
	logic [SLOT_W-1:0]       tail_q;
	logic [CNT_W-1:0]        brx_q;
	logic                    in_msg_q;
	logic [SLOT_COUNT-1:0]   occ_q;
	logic [CNT_W-1:0]        rd_idx_q;

	logic                    p_s1;
	logic                    pst_s1;
	logic [IDX_W-1:0]        pidx_s1;
	logic [BYTE_W-1:0]       rdata_s1;
	logic [CNT_W-1:0]        len_rd_s1;

	logic [BYTE_W-1:0]       byte_mem [SLOT_COUNT*SLOT_BYTES];
	logic [CNT_W-1:0]        len_mem  [SLOT_COUNT];

	logic                    accept;
	logic                    is_push;
	logic                    is_pop;
	logic                    is_clear;
	logic                    first;
	logic                    overwrite;
	logic [CNT_W-1:0]        brx_cur;
	logic                    store;
	logic [CNT_W-1:0]        brx_nxt;
	logic [ADDR_W-1:0]       wr_addr;
	logic                    push_wr;
	logic                    commit;
	logic                    pop_full;
	logic                    pop_empty;
	logic                    stream_more;
	logic                    finish;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_idx_c;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    rd_take;
	res_t                    res_c;

	assign req.ready = (state_q == ST_IDLE) && !p_s1;
	assign accept    = req.valid && req.ready;
	assign is_push   = accept && (req.cmd == CMD_PUSH);
	assign is_pop    = accept && (req.cmd == CMD_POP);
	assign is_clear  = accept && (req.cmd == CMD_CLEAR);

	assign first     = !in_msg_q;
	assign overwrite = first && (head_q == tail_q) && occ_q[head_q];
	assign brx_cur   = first ? '0 : brx_q;
	assign store     = brx_cur < CNT_W'(SLOT_BYTES);
	assign brx_nxt   = store ? brx_cur + CNT_W'(1) : brx_cur;
	assign wr_addr   = slot_addr(head_q, brx_cur[IDX_W-1:0]);
	assign push_wr   = is_push && store;
	assign commit    = is_push && req.push_last;

	assign pop_full    = is_pop && occ_q[tail_q];
	assign pop_empty   = is_pop && !occ_q[tail_q];
	assign stream_more = (state_q == ST_STREAM) && (rd_idx_q < len_rd_s1);
	assign finish      = (state_q == ST_STREAM) && (rd_idx_q == len_rd_s1);
	assign rd_en       = pop_full || (stream_more && (!p_s1 || rd_take));
	assign rd_idx_c    = pop_full ? '0 : rd_idx_q[IDX_W-1:0];
	assign rd_addr     = slot_addr(tail_q, rd_idx_c);

	always_ff @(posedge clk) begin
		if (push_wr) begin
			byte_mem[wr_addr] <= req.push_byte;
		end
		if (rd_en) begin
			rdata_s1 <= byte_mem[rd_addr];
		end
		if (commit) begin
			len_mem[head_q] <= brx_nxt;
		end
		if (pop_full) begin
			len_rd_s1 <= len_mem[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pidx_s1 <= rd_idx_c;
			pst_s1  <= 1'b0;
		end else if (pop_empty) begin
			pst_s1  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			brx_q    <= '0;
			in_msg_q <= 1'b0;
			occ_q    <= '0;
			rd_idx_q <= '0;
			p_s1     <= 1'b0;
		end else begin
			if (rd_en || pop_empty) begin
				p_s1 <= 1'b1;
			end else if (rd_take) begin
				p_s1 <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_push) begin
						if (overwrite) begin
							tail_q <= next_slot(tail_q);
						end
						if (first) begin
							occ_q[head_q] <= 1'b0;
						end
						brx_q <= brx_nxt;
						if (req.push_last) begin
							occ_q[head_q] <= 1'b1;
							head_q        <= next_slot(head_q);
							in_msg_q      <= 1'b0;
						end else begin
							in_msg_q <= 1'b1;
						end
					end else if (pop_full) begin
						state_q  <= ST_STREAM;
						rd_idx_q <= CNT_W'(1);
					end else if (is_clear) begin
						head_q   <= '0;
						tail_q   <= '0;
						brx_q    <= '0;
						in_msg_q <= 1'b0;
						occ_q    <= '0;
					end
				end
				ST_STREAM: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (finish) begin
						state_q       <= ST_IDLE;
						occ_q[tail_q] <= 1'b0;
						tail_q        <= next_slot(tail_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_c.status         = pst_s1;
		res_c.pop_byte       = pst_s1 ? '0 : rdata_s1;
		res_c.pop_last       = pst_s1 || ((CNT_W'(pidx_s1) + CNT_W'(1)) == len_rd_s1);
		res_c.message_length = pst_s1 ? '0 : LEN_W'(len_rd_s1);
	end

	omrb_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (p_s1),
		.res        (res_c),
		.take       (rd_take),
		.rsp        (rsp)
	);

	// A new read must never overwrite a staged byte that has not moved on.
	a_read_into_free_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && p_s1) |-> rd_take)
		else $error("byte read issued over a staged byte");

	// While streaming, the stored length is nonzero and the read index never passes it.
	a_stream_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> ((len_rd_s1 != '0) && (rd_idx_q <= len_rd_s1)))
		else $error("stream index out of range");

	// Between messages, head meeting tail on an empty slot means the whole ring is empty.
	a_empty_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_msg_q && (head_q == tail_q) && !occ_q[tail_q]) |-> (occ_q == '0))
		else $error("occupancy disagrees with head and tail");

	// A committed push always leaves its slot occupied.
	a_commit_occupies: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> occ_q[$past(head_q)])
		else $error("committed slot not marked occupied");

endmodule
